/* rtl/core/pac_pkg.sv */
package pac_pkg;

  localparam int CoordW = 16;
  localparam int AreaAccW = 48;
  localparam int AreaOutW = 47;
  localparam int MomW = 64;
  localparam int QueueDepth = 2;

  typedef struct packed {
    logic signed [CoordW-1:0] x0;
    logic signed [CoordW-1:0] y0;
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] y1;
    logic                     close;
  } seg_t;

endpackage

/* rtl/core/pac_front.sv */
module pac_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic signed [pac_pkg::CoordW-1:0] x_coord,
  input  logic signed [pac_pkg::CoordW-1:0] y_coord,
  input  logic                              last_vertex,
  output logic                              seg_push,
  output pac_pkg::seg_t                     seg,
  input  logic                              seg_full
);

  logic                              have_first;
  logic                              pend;
  logic signed [pac_pkg::CoordW-1:0] first_x;
  logic signed [pac_pkg::CoordW-1:0] first_y;
  logic signed [pac_pkg::CoordW-1:0] prev_x;
  logic signed [pac_pkg::CoordW-1:0] prev_y;
  logic                              acc;

  assign full = pend || seg_full;
  assign acc  = push && !full;

  always_comb begin
    seg = '0;
    seg_push = 1'b0;
    if (pend) begin
      seg = '{x0: prev_x, y0: prev_y, x1: first_x, y1: first_y, close: 1'b1};
      seg_push = !seg_full;
    end else if (!have_first) begin
      seg = '{x0: x_coord, y0: y_coord, x1: x_coord, y1: y_coord, close: 1'b1};
      seg_push = acc && last_vertex;
    end else begin
      seg = '{x0: prev_x, y0: prev_y, x1: x_coord, y1: y_coord, close: 1'b0};
      seg_push = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_first <= 1'b0;
      pend <= 1'b0;
    end else begin
      if (pend && !seg_full) pend <= 1'b0;
      if (acc) begin
        if (!have_first) begin
          have_first <= !last_vertex;
        end else if (last_vertex) begin
          have_first <= 1'b0;
          pend <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      prev_x <= x_coord;
      prev_y <= y_coord;
      if (!have_first) begin
        first_x <= x_coord;
        first_y <= y_coord;
      end
    end
  end

endmodule

/* rtl/core/pac_fifo.sv */
module pac_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pac_pkg::seg_t din,
  output logic          full,
  input  logic          pop,
  output pac_pkg::seg_t dout,
  output logic          empty
);

  localparam int AW = $clog2(pac_pkg::QueueDepth);

  pac_pkg::seg_t mem [pac_pkg::QueueDepth];
  logic [AW-1:0] wr;
  logic [AW-1:0] rd;
  logic [AW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign full    = count == (AW+1)'(pac_pkg::QueueDepth);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr <= '0;
      rd <= '0;
      count <= '0;
    end else begin
      if (do_push) wr <= wr + 1'b1;
      if (do_pop) rd <= rd + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr] <= din;
  end

endmodule

/* rtl/core/pac_back.sv */
module pac_back (
  input  logic                                clk,
  input  logic                                rst,
  input  pac_pkg::seg_t                       seg,
  input  logic                                seg_empty,
  output logic                                seg_pop,
  output logic                                empty,
  input  logic                                pop,
  output logic        [pac_pkg::AreaOutW-1:0] area,
  output logic signed [pac_pkg::CoordW-1:0]   centroid_x,
  output logic signed [pac_pkg::CoordW-1:0]   centroid_y,
  output logic                                degenerate
);

  localparam logic [2:0] ST_RUN   = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;
  localparam logic [2:0] ST_LOADX = 3'd2;
  localparam logic [2:0] ST_DIVX  = 3'd3;
  localparam logic [2:0] ST_LOADY = 3'd4;
  localparam logic [2:0] ST_DIVY  = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  localparam int CW = pac_pkg::CoordW;
  localparam int AW = pac_pkg::AreaAccW;
  localparam int MW = pac_pkg::MomW;
  localparam int QW = CW + 1;
  localparam int DW = AW + 2;
  localparam int SW = DW + CW;

  function automatic logic [CW-1:0] sat(input logic [QW-1:0] q, input logic ovf,
                                        input logic neg);
    logic [QW-1:0] nq;
    nq = QW'(0) - q;
    if (neg) begin
      sat = (ovf || q > {2'b01, {(CW-1){1'b0}}}) ? {1'b1, {(CW-1){1'b0}}} : nq[CW-1:0];
    end else begin
      sat = (ovf || q > {2'b00, {(CW-1){1'b1}}}) ? {1'b0, {(CW-1){1'b1}}} : q[CW-1:0];
    end
  endfunction

  logic [2:0] state;

  logic                     v1, v2, v3;
  logic                     c1, c2, c3;
  logic signed [2*CW-1:0]   p1, p2;
  logic signed [CW:0]       sx1, sy1, sx2, sy2;
  logic signed [2*CW:0]     cr2, cr3;
  logic signed [3*CW+1:0]   mx3, my3;

  logic [AW-1:0] area_acc;
  logic [MW-1:0] mx_acc;
  logic [MW-1:0] my_acc;

  logic          a_neg, x_neg, y_neg;
  logic [AW-1:0] amag;
  logic [MW-1:0] mag_x, mag_y;
  logic [DW-1:0] d;
  logic [DW-1:0] d_comb;
  logic [MW-1:0] rem;
  logic [SW-1:0] dsh;
  logic [4:0]    cnt;
  logic [CW-1:0] q;
  logic          ovf;
  logic          ge;
  logic [QW-1:0] qf;
  logic [CW-1:0] cx;
  logic [CW-1:0] cy;
  logic          out_v;
  logic          inflight;

  assign inflight = (v1 && c1) || (v2 && c2) || (v3 && c3);
  assign seg_pop  = !seg_empty && state == ST_RUN && !inflight;
  assign empty    = !out_v;
  assign d_comb   = {2'b00, amag} + {1'b0, amag, 1'b0};
  assign ge       = {3'b000, rem} >= {1'b0, dsh};
  assign qf       = {q, ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= seg_pop;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    p1  <= seg.x0 * seg.y1;
    p2  <= seg.x1 * seg.y0;
    sx1 <= {seg.x0[CW-1], seg.x0} + {seg.x1[CW-1], seg.x1};
    sy1 <= {seg.y0[CW-1], seg.y0} + {seg.y1[CW-1], seg.y1};
    c1  <= seg.close;
    cr2 <= {p1[2*CW-1], p1} - {p2[2*CW-1], p2};
    sx2 <= sx1;
    sy2 <= sy1;
    c2  <= c1;
    mx3 <= sx2 * cr2;
    my3 <= sy2 * cr2;
    cr3 <= cr2;
    c3  <= c2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      area_acc <= '0;
      mx_acc <= '0;
      my_acc <= '0;
      out_v <= 1'b0;
    end else begin
      if (state == ST_OUT && (!out_v || pop)) out_v <= 1'b1;
      else if (pop && out_v) out_v <= 1'b0;
      case (state)
        ST_RUN: begin
          if (v3) begin
            area_acc <= area_acc + {{(AW-2*CW-1){cr3[2*CW]}}, cr3};
            mx_acc <= mx_acc + {{(MW-3*CW-2){mx3[3*CW+1]}}, mx3};
            my_acc <= my_acc + {{(MW-3*CW-2){my3[3*CW+1]}}, my3};
            if (c3) state <= ST_PREP;
          end
        end
        ST_PREP:  state <= ST_LOADX;
        ST_LOADX: state <= ST_DIVX;
        ST_DIVX:  if (cnt == 5'd0) state <= ST_LOADY;
        ST_LOADY: state <= ST_DIVY;
        ST_DIVY:  if (cnt == 5'd0) state <= ST_OUT;
        ST_OUT: begin
          if (!out_v || pop) begin
            area_acc <= '0;
            mx_acc <= '0;
            my_acc <= '0;
            state <= ST_RUN;
          end
        end
        default: state <= ST_RUN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_PREP: begin
        a_neg <= area_acc[AW-1];
        x_neg <= mx_acc[MW-1];
        y_neg <= my_acc[MW-1];
        amag  <= area_acc[AW-1] ? AW'(0) - area_acc : area_acc;
        mag_x <= mx_acc[MW-1] ? MW'(0) - mx_acc : mx_acc;
        mag_y <= my_acc[MW-1] ? MW'(0) - my_acc : my_acc;
      end
      ST_LOADX: begin
        d   <= d_comb;
        dsh <= {d_comb, {CW{1'b0}}};
        rem <= mag_x;
        cnt <= 5'(CW);
      end
      ST_LOADY: begin
        dsh <= {d, {CW{1'b0}}};
        rem <= mag_y;
        cnt <= 5'(CW);
      end
      ST_DIVX, ST_DIVY: begin
        if (cnt == 5'(CW)) ovf <= {3'b000, rem} >= {dsh, 1'b0};
        if (ge) rem <= rem - dsh[MW-1:0];
        dsh <= dsh >> 1;
        q <= qf[CW-1:0];
        cnt <= cnt - 1'b1;
        if (cnt == 5'd0) begin
          if (state == ST_DIVX) cx <= sat(qf, ovf, x_neg ^ a_neg);
          else cy <= sat(qf, ovf, y_neg ^ a_neg);
        end
      end
      ST_OUT: begin
        if (!out_v || pop) begin
          degenerate <= amag == '0;
          area <= (amag == '0) ? '0 : amag[AW-1:1];
          centroid_x <= (amag == '0) ? '0 : cx;
          centroid_y <= (amag == '0) ? '0 : cy;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/core/polygon_area_centroid.sv */
// Path: with the back end idle, a last vertex reaches its result through the
// closing edge, a 3-stage multiply pipe and two 17-step restoring divisions.
// Throughput: one vertex per cycle while full is low; a pending closing edge raises
// full, and the edge queue fills and push stalls while the shared divider runs.
// Reset: synchronous active-high rst empties the edge queue and clears all sums.
module polygon_area_centroid (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic signed [pac_pkg::CoordW-1:0]   x_coord,
  input  logic signed [pac_pkg::CoordW-1:0]   y_coord,
  input  logic                                last_vertex,
  output logic                                empty,
  input  logic                                pop,
  output logic        [pac_pkg::AreaOutW-1:0] area,
  output logic signed [pac_pkg::CoordW-1:0]   centroid_x,
  output logic signed [pac_pkg::CoordW-1:0]   centroid_y,
  output logic                                degenerate
);

  pac_pkg::seg_t f_seg;
  pac_pkg::seg_t b_seg;
  logic          f_push;
  logic          q_full;
  logic          q_empty;
  logic          b_pop;

  pac_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .x_coord(x_coord), .y_coord(y_coord), .last_vertex(last_vertex),
    .seg_push(f_push), .seg(f_seg), .seg_full(q_full)
  );

  pac_fifo u_fifo (
    .clk(clk), .rst(rst), .push(f_push), .din(f_seg), .full(q_full),
    .pop(b_pop), .dout(b_seg), .empty(q_empty)
  );

  pac_back u_back (
    .clk(clk), .rst(rst), .seg(b_seg), .seg_empty(q_empty), .seg_pop(b_pop),
    .empty(empty), .pop(pop), .area(area), .centroid_x(centroid_x),
    .centroid_y(centroid_y), .degenerate(degenerate)
  );

endmodule

/* rtl/core/pac_checker.sv */
module pac_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                full,
  input logic                                empty,
  input logic                                pop,
  input logic        [pac_pkg::AreaOutW-1:0] area,
  input logic signed [pac_pkg::CoordW-1:0]   centroid_x,
  input logic signed [pac_pkg::CoordW-1:0]   centroid_y,
  input logic                                degenerate
);

  a_reset_idle: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("not idle after reset");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && degenerate) |-> (area == '0 && centroid_x == '0 && centroid_y == '0))
    else $error("degenerate result not zero");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(area) && $stable(centroid_x)
                          && $stable(centroid_y) && $stable(degenerate)))
    else $error("result changed while waiting");

endmodule

bind polygon_area_centroid pac_checker u_checker (
  .clk(clk), .rst(rst), .full(full), .empty(empty), .pop(pop), .area(area),
  .centroid_x(centroid_x), .centroid_y(centroid_y), .degenerate(degenerate)
);
